### hw/rtl/sc1kt_pkg.sv
`timescale 1ns / 1ps

package sc1kt_pkg;

   // item kinds on the request side
   localparam logic [1:0] ACT_SCAN    = 2'd0;
   localparam logic [1:0] ACT_REFRESH = 2'd1;
   localparam logic [1:0] ACT_QUERY   = 2'd2;

   // scan bytes with a meaning of their own
   localparam logic [7:0] SC_NULL      = 8'h00;
   localparam logic [7:0] SC_EXT       = 8'hE0;
   localparam logic [7:0] SC_PAUSE     = 8'hE1;
   localparam logic [7:0] SC_FAKE_MAKE = 8'h2A;
   localparam logic [7:0] SC_FAKE_BRK  = 8'hB7;

   localparam logic [2:0] PAUSE_SKIP = 3'd5;

   localparam logic [7:0] NO_KEY    = 8'hFF;
   localparam logic [7:0] KEY_UP    = 8'd96;
   localparam logic [7:0] KEY_LEFT  = 8'd97;
   localparam logic [7:0] KEY_DOWN  = 8'd98;
   localparam logic [7:0] KEY_RIGHT = 8'd99;
   localparam logic [7:0] KEY_PRTSC = 8'd102;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_EXT,
      PH_FAKE_MAKE_SKIP,
      PH_FAKE_BRK_SKIP,
      PH_FAKE_MAKE_LAST,
      PH_FAKE_BRK_LAST
   } phase_type;

   // plain make code to key number
   localparam logic [7:0] PLAIN_KEYS [128] = '{
      8'hFF, 8'd56, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32,
      8'd33, 8'd34, 8'd35, 8'd26, 8'd37, 8'd38, 8'd47, 8'd49,
      8'd16, 8'd22, 8'd4,  8'd17, 8'd19, 8'd24, 8'd20, 8'd8,
      8'd14, 8'd15, 8'd40, 8'd41, 8'd55, 8'd52, 8'd0,  8'd18,
      8'd3,  8'd5,  8'd6,  8'd7,  8'd9,  8'd10, 8'd11, 8'd42,
      8'd43, 8'd36, 8'd51, 8'd39, 8'd25, 8'd23, 8'd2,  8'd21,
      8'd1,  8'd13, 8'd12, 8'd44, 8'd45, 8'd46, 8'd54, 8'd71,
      8'd53, 8'd48, 8'd50, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61,
      8'd62, 8'd63, 8'd64, 8'd65, 8'd66, 8'd70, 8'd69, 8'd82,
      8'd83, 8'd84, 8'd72, 8'd79, 8'd80, 8'd81, 8'd73, 8'd76,
      8'd77, 8'd78, 8'd75, 8'd74, 8'hFF, 8'hFF, 8'hFF, 8'd67,
      8'd68, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
   };

   function automatic logic [7:0] ext_key(input logic [6:0] code);
      logic [7:0] k;
      k = NO_KEY;
      case (code)
         7'h5B: k = 8'd85;
         7'h1D: k = 8'd86;
         7'h38: k = 8'd87;
         7'h5C: k = 8'd88;
         7'h5D: k = 8'd89;
         7'h52: k = 8'd90;
         7'h47: k = 8'd91;
         7'h4F: k = 8'd92;
         7'h49: k = 8'd93;
         7'h51: k = 8'd94;
         7'h53: k = 8'd95;
         7'h48: k = KEY_UP;
         7'h4B: k = KEY_LEFT;
         7'h50: k = KEY_DOWN;
         7'h4D: k = KEY_RIGHT;
         7'h35: k = 8'd100;
         7'h1C: k = 8'd101;
         default: k = NO_KEY;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] fake_make_key(input logic [7:0] code);
      logic [7:0] k;
      k = NO_KEY;
      case (code)
         8'h48: k = KEY_UP;
         8'h4B: k = KEY_LEFT;
         8'h50: k = KEY_DOWN;
         8'h4D: k = KEY_RIGHT;
         8'h37: k = KEY_PRTSC;
         default: k = NO_KEY;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] fake_break_key(input logic [7:0] code);
      logic [7:0] k;
      k = NO_KEY;
      case (code)
         8'hC8: k = KEY_UP;
         8'hCB: k = KEY_LEFT;
         8'hD0: k = KEY_DOWN;
         8'hCD: k = KEY_RIGHT;
         8'hAA: k = KEY_PRTSC;
         default: k = NO_KEY;
      endcase
      return k;
   endfunction

endpackage

### hw/rtl/scancode_set1_key_tracker.sv
`timescale 1ns / 1ps

// scan code set 1 key tracker
// req channel: one item per scan byte, snapshot refresh or key query.
//   req_tuser holds the item kind (0 scan byte, 1 refresh, 2 query).
// rsp channel: exactly one result item per request item, in order.
//   scan bytes report the key written (if any), queries report the key's
//   held / went-down / went-up bits against the last snapshot.
// an accepted item goes from the input register to the result register, which
//   drives rsp_tvalid; it moves on only when the result register is free.
// throughput: one item per cycle unless rsp stalls; the decode is a table
//   lookup plus the prefix state update, done between the input and result registers.
// the input register lets one more item in while a result sits unread.
// when rsp_tready is low both registers fill and req_tready drops; nothing
//   is lost or repeated, state only moves when an item enters the result reg.
// reset: synchronous, clears both key maps (all keys up), the prefix state
//   and the pause skip count; both registers come up empty.
module scancode_set1_key_tracker #(
   parameter int KEY_SLOTS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // scan_byte[7:0], key_index[14:8], zero[15]
   input  logic [1:0]  req_tuser,  // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // key_held[0], key_went_down[1], key_went_up[2],
                                   // event_valid[3], event_key[10:4],
                                   // event_down[11], zero[15:12]
);

   localparam int IDX_W = $clog2(KEY_SLOTS);

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   logic [1:0]            s1_action_ff;
   logic [7:0]            s1_byte_ff;
   logic [6:0]            s1_key_index_ff;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [15:0]           out_data_ff, out_data_in;

   // tracker state
   logic [KEY_SLOTS-1:0]  held_map_ff, held_map_in;
   logic [KEY_SLOTS-1:0]  snapshot_map_ff, snapshot_map_in;
   sc1kt_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]            pause_left_ff, pause_left_in;

   logic                  advance;
   logic                  req_fire;

   // decode results
   logic [7:0]            key;
   logic                  down;
   logic                  ev_valid;
   logic                  q_held, q_snap, q_in_range;
   logic [IDX_W-1:0]      q_idx;

   // result register frees when empty or read this cycle
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_action_ff    <= req_tuser;
         s1_byte_ff      <= req_tdata[7:0];
         s1_key_index_ff <= req_tdata[14:8];
      end
      if (advance && s1_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   // query lookup
   assign q_in_range = (9'(s1_key_index_ff) < 9'(KEY_SLOTS));
   assign q_idx      = IDX_W'(s1_key_index_ff);
   assign q_held     = q_in_range ? held_map_ff[q_idx] : 1'b0;
   assign q_snap     = q_in_range ? snapshot_map_ff[q_idx] : 1'b0;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         held_map_ff     <= '0;
         snapshot_map_ff <= '0;
         phase_ff        <= sc1kt_pkg::PH_IDLE;
         pause_left_ff   <= 3'd0;
      end else if (advance && s1_valid_ff) begin
         held_map_ff     <= held_map_in;
         snapshot_map_ff <= snapshot_map_in;
         phase_ff        <= phase_in;
         pause_left_ff   <= pause_left_in;
      end
   end

   // next state and result
   always_comb begin
      held_map_in     = held_map_ff;
      snapshot_map_in = snapshot_map_ff;
      phase_in        = phase_ff;
      pause_left_in   = pause_left_ff;
      key             = sc1kt_pkg::NO_KEY;
      down            = 1'b0;
      out_data_in     = '0;

      unique case (s1_action_ff)
         sc1kt_pkg::ACT_REFRESH: begin
            snapshot_map_in = held_map_ff;
         end
         sc1kt_pkg::ACT_QUERY: begin
            out_data_in[0] = q_held;
            out_data_in[1] = q_held && !q_snap;
            out_data_in[2] = !q_held && q_snap;
         end
         sc1kt_pkg::ACT_SCAN: begin
            // null bytes never touch the sequence state
            if (s1_byte_ff != sc1kt_pkg::SC_NULL) begin
               if (pause_left_ff != 3'd0) begin
                  pause_left_in = pause_left_ff - 3'd1;
               end else begin
                  unique case (phase_ff)
                     sc1kt_pkg::PH_IDLE: begin
                        if (s1_byte_ff == sc1kt_pkg::SC_EXT) begin
                           phase_in = sc1kt_pkg::PH_EXT;
                        end else if (s1_byte_ff == sc1kt_pkg::SC_PAUSE) begin
                           pause_left_in = sc1kt_pkg::PAUSE_SKIP;
                        end else begin
                           key  = sc1kt_pkg::PLAIN_KEYS[s1_byte_ff[6:0]];
                           down = !s1_byte_ff[7];
                        end
                     end
                     sc1kt_pkg::PH_EXT: begin
                        phase_in = sc1kt_pkg::PH_IDLE;
                        if (s1_byte_ff == sc1kt_pkg::SC_FAKE_MAKE) begin
                           phase_in = sc1kt_pkg::PH_FAKE_MAKE_SKIP;
                        end else if (s1_byte_ff == sc1kt_pkg::SC_FAKE_BRK) begin
                           phase_in = sc1kt_pkg::PH_FAKE_BRK_SKIP;
                        end else if (s1_byte_ff != sc1kt_pkg::SC_EXT &&
                                     s1_byte_ff != sc1kt_pkg::SC_PAUSE) begin
                           key  = sc1kt_pkg::ext_key(s1_byte_ff[6:0]);
                           down = !s1_byte_ff[7];
                        end
                     end
                     // inner E0 of a fake-shift pair, skipped whatever it is
                     sc1kt_pkg::PH_FAKE_MAKE_SKIP: phase_in = sc1kt_pkg::PH_FAKE_MAKE_LAST;
                     sc1kt_pkg::PH_FAKE_BRK_SKIP:  phase_in = sc1kt_pkg::PH_FAKE_BRK_LAST;
                     sc1kt_pkg::PH_FAKE_MAKE_LAST: begin
                        phase_in = sc1kt_pkg::PH_IDLE;
                        key      = sc1kt_pkg::fake_make_key(s1_byte_ff);
                        down     = 1'b1;
                     end
                     sc1kt_pkg::PH_FAKE_BRK_LAST: begin
                        phase_in = sc1kt_pkg::PH_IDLE;
                        key      = sc1kt_pkg::fake_break_key(s1_byte_ff);
                        down     = 1'b0;
                     end
                     default: phase_in = sc1kt_pkg::PH_IDLE;
                  endcase
               end
            end
         end
         default: begin
            // unused kind, nothing changes
         end
      endcase

      ev_valid = (key != sc1kt_pkg::NO_KEY) && (9'(key) < 9'(KEY_SLOTS));
      if (ev_valid) begin
         held_map_in[IDX_W'(key)] = down;
         out_data_in[3]           = 1'b1;
         out_data_in[10:4]        = key[6:0];
         out_data_in[11]          = down;
      end
   end

endmodule

### tb/scancode_set1_key_tracker_tb.sv
`timescale 1ns / 1ps

module scancode_set1_key_tracker_tb;

   localparam int KEY_SLOTS    = 128;
   localparam int STALL_LIMIT  = 1000;  // cycles with no item moving on either side
   localparam int RANDOM_ITEMS = 850;
   localparam int CALM_TAIL    = 100;   // last items run with both sides always ready
   localparam int DIRECTED_ROWS = 30;

   // item kind the block does not use
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic [7:0] NO_KEY = sc1kt_pkg::NO_KEY;

   // one result item, packed the way rsp_tdata carries it
   typedef struct packed {
      logic [3:0] zero;
      logic       event_down;
      logic [6:0] event_key;
      logic       event_valid;
      logic       key_went_up;
      logic       key_went_down;
      logic       key_held;
   } key_report_type;

   // one request item plus an optional hand-written result
   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  scan_byte;
      logic [6:0]  key_index;
      logic        fixed_report;
      logic [15:0] report_bits;
   } key_item_type;

   // plain make code (low 7 bits) to key number
   localparam logic [7:0] MAKE_TO_KEY [128] = '{
      NO_KEY, 8'd56, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32,
      8'd33, 8'd34, 8'd35, 8'd26, 8'd37, 8'd38, 8'd47, 8'd49,
      8'd16, 8'd22, 8'd4,  8'd17, 8'd19, 8'd24, 8'd20, 8'd8,
      8'd14, 8'd15, 8'd40, 8'd41, 8'd55, 8'd52, 8'd0,  8'd18,
      8'd3,  8'd5,  8'd6,  8'd7,  8'd9,  8'd10, 8'd11, 8'd42,
      8'd43, 8'd36, 8'd51, 8'd39, 8'd25, 8'd23, 8'd2,  8'd21,
      8'd1,  8'd13, 8'd12, 8'd44, 8'd45, 8'd46, 8'd54, 8'd71,
      8'd53, 8'd48, 8'd50, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61,
      8'd62, 8'd63, 8'd64, 8'd65, 8'd66, 8'd70, 8'd69, 8'd82,
      8'd83, 8'd84, 8'd72, 8'd79, 8'd80, 8'd81, 8'd73, 8'd76,
      8'd77, 8'd78, 8'd75, 8'd74, NO_KEY, NO_KEY, NO_KEY, 8'd67,
      8'd68, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY,
      NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY,
      NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY,
      NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY,
      NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY
   };

   // extended codes that name a key (after the E0 prefix)
   localparam logic [6:0] EXT_CODES [17] = '{
      7'h5B, 7'h1D, 7'h38, 7'h5C, 7'h5D, 7'h52, 7'h47, 7'h4F, 7'h49,
      7'h51, 7'h53, 7'h48, 7'h4B, 7'h50, 7'h4D, 7'h35, 7'h1C
   };

   // last byte of a fake-shift press / release
   localparam logic [7:0] FAKE_PRESS_CODES [5]   = '{8'h48, 8'h4B, 8'h50, 8'h4D, 8'h37};
   localparam logic [7:0] FAKE_RELEASE_CODES [5] = '{8'hC8, 8'hCB, 8'hD0, 8'hCD, 8'hAA};

   // directed items; rows with fixed_report set carry the result written by hand
   localparam key_item_type DIRECTED [DIRECTED_ROWS] = '{
      '{sc1kt_pkg::ACT_QUERY, 8'h00, 7'd0, 1'b1, 16'h0000},  // all keys up after reset
      '{sc1kt_pkg::ACT_QUERY, 8'hFF, 7'd127, 1'b1, 16'h0000},  // highest key number
      '{ACT_UNUSED, 8'hFF, 7'd127, 1'b1, 16'h0000},  // unused kind: all zero
      '{sc1kt_pkg::ACT_SCAN, sc1kt_pkg::SC_NULL, 7'd127, 1'b1, 16'h0000},  // null byte dropped
      '{sc1kt_pkg::ACT_SCAN, 8'h1E, 7'd0, 1'b1, 16'h0808},  // 'a' pressed, key 0
      '{sc1kt_pkg::ACT_QUERY, 8'h00, 7'd0, 1'b1, 16'h0003},  // held and newly down
      '{sc1kt_pkg::ACT_REFRESH, 8'h00, 7'd0, 1'b0, 16'h0000},
      '{sc1kt_pkg::ACT_SCAN, 8'h9E, 7'd0, 1'b1, 16'h0008},  // 'a' released
      '{sc1kt_pkg::ACT_QUERY, 8'h00, 7'd0, 1'b1, 16'h0004},  // newly up
      '{sc1kt_pkg::ACT_SCAN, sc1kt_pkg::SC_EXT, 7'd0, 1'b0, 16'h0000},  // left gui press
      '{sc1kt_pkg::ACT_SCAN, 8'h5B, 7'd0, 1'b0, 16'h0000},
      '{sc1kt_pkg::ACT_SCAN, sc1kt_pkg::SC_EXT, 7'd0, 1'b0, 16'h0000},  // print screen press
      '{sc1kt_pkg::ACT_SCAN, sc1kt_pkg::SC_FAKE_MAKE, 7'd0, 1'b0, 16'h0000},
      '{sc1kt_pkg::ACT_SCAN, sc1kt_pkg::SC_EXT, 7'd0, 1'b0, 16'h0000},
      '{sc1kt_pkg::ACT_SCAN, 8'h37, 7'd0, 1'b0, 16'h0000},
      '{sc1kt_pkg::ACT_SCAN, sc1kt_pkg::SC_EXT, 7'd0, 1'b0, 16'h0000},  // fake release clears
      '{sc1kt_pkg::ACT_SCAN, sc1kt_pkg::SC_FAKE_BRK, 7'd0, 1'b0, 16'h0000},
      '{sc1kt_pkg::ACT_SCAN, sc1kt_pkg::SC_EXT, 7'd0, 1'b0, 16'h0000},
      '{sc1kt_pkg::ACT_SCAN, 8'hAA, 7'd0, 1'b0, 16'h0000},
      '{sc1kt_pkg::ACT_SCAN, sc1kt_pkg::SC_EXT, 7'd0, 1'b0, 16'h0000},  // prefix after prefix
      '{sc1kt_pkg::ACT_SCAN, sc1kt_pkg::SC_EXT, 7'd0, 1'b0, 16'h0000},
      '{sc1kt_pkg::ACT_SCAN, sc1kt_pkg::SC_PAUSE, 7'd0, 1'b0, 16'h0000},  // five bytes skipped
      '{sc1kt_pkg::ACT_SCAN, sc1kt_pkg::SC_NULL, 7'd0, 1'b0, 16'h0000},  // null does not count
      '{sc1kt_pkg::ACT_SCAN, 8'h1D, 7'd0, 1'b0, 16'h0000},
      '{sc1kt_pkg::ACT_SCAN, 8'h45, 7'd0, 1'b0, 16'h0000},
      '{sc1kt_pkg::ACT_SCAN, sc1kt_pkg::SC_PAUSE, 7'd0, 1'b0, 16'h0000},
      '{sc1kt_pkg::ACT_SCAN, 8'h9D, 7'd0, 1'b0, 16'h0000},
      '{sc1kt_pkg::ACT_SCAN, 8'hC5, 7'd0, 1'b0, 16'h0000},
      '{sc1kt_pkg::ACT_SCAN, 8'hFF, 7'd0, 1'b1, 16'h0000},  // unknown byte ignored
      '{sc1kt_pkg::ACT_QUERY, 8'h00, 7'd102, 1'b0, 16'h0000}  // print screen after release
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // scan_byte[7:0], key_index[14:8], zero[15]
   logic [1:0]  req_tuser = '0;   // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // key_held[0], key_went_down[1], key_went_up[2],
                                  // event_valid[3], event_key[10:4], event_down[11]

   // predicted state of the tracker
   logic [KEY_SLOTS-1:0] keys_down;
   logic [KEY_SLOTS-1:0] keys_at_refresh;
   sc1kt_pkg::phase_type seq_phase;
   logic [2:0]           pause_left;

   key_report_type expected_reports [$];
   key_item_type   stimulus [$];
   int             mismatches = 0;
   int             idle_cycles = 0;
   int             stall_left = 0;
   bit             calm = 1'b0;

   scancode_set1_key_tracker #(
      .KEY_SLOTS(KEY_SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] extended_key(input logic [6:0] code);
      case (code)
         7'h5B: return 8'd85;
         7'h1D: return 8'd86;
         7'h38: return 8'd87;
         7'h5C: return 8'd88;
         7'h5D: return 8'd89;
         7'h52: return 8'd90;
         7'h47: return 8'd91;
         7'h4F: return 8'd92;
         7'h49: return 8'd93;
         7'h51: return 8'd94;
         7'h53: return 8'd95;
         7'h48: return sc1kt_pkg::KEY_UP;
         7'h4B: return sc1kt_pkg::KEY_LEFT;
         7'h50: return sc1kt_pkg::KEY_DOWN;
         7'h4D: return sc1kt_pkg::KEY_RIGHT;
         7'h35: return 8'd100;
         7'h1C: return 8'd101;
         default: return NO_KEY;
      endcase
   endfunction

   // top bit of the case word selects the release table
   function automatic logic [7:0] fake_shift_key(input logic releasing, input logic [7:0] code);
      case ({releasing, code})
         9'h048, 9'h1C8: return sc1kt_pkg::KEY_UP;
         9'h04B, 9'h1CB: return sc1kt_pkg::KEY_LEFT;
         9'h050, 9'h1D0: return sc1kt_pkg::KEY_DOWN;
         9'h04D, 9'h1CD: return sc1kt_pkg::KEY_RIGHT;
         9'h037, 9'h1AA: return sc1kt_pkg::KEY_PRTSC;
         default: return NO_KEY;
      endcase
   endfunction

   // applies one item to the predicted state and returns its result
   function automatic key_report_type predict_key_report(input key_item_type item);
      key_report_type r;
      logic [7:0]     key;
      logic           down;
      logic [7:0]     b;
      r = '0;
      key = NO_KEY;
      down = 1'b0;
      b = item.scan_byte;
      case (item.action)
         sc1kt_pkg::ACT_REFRESH: keys_at_refresh = keys_down;
         sc1kt_pkg::ACT_QUERY: begin
            if (item.key_index < KEY_SLOTS) begin
               r.key_held      = keys_down[item.key_index];
               r.key_went_down = keys_down[item.key_index] & ~keys_at_refresh[item.key_index];
               r.key_went_up   = ~keys_down[item.key_index] & keys_at_refresh[item.key_index];
            end
         end
         sc1kt_pkg::ACT_SCAN: begin
            if (b == sc1kt_pkg::SC_NULL) begin
               // dropped everywhere, even inside a pause
            end else if (pause_left != 3'd0) begin
               pause_left = pause_left - 3'd1;
            end else begin
               case (seq_phase)
                  sc1kt_pkg::PH_IDLE: begin
                     if (b == sc1kt_pkg::SC_EXT) begin
                        seq_phase = sc1kt_pkg::PH_EXT;
                     end else if (b == sc1kt_pkg::SC_PAUSE) begin
                        pause_left = sc1kt_pkg::PAUSE_SKIP;
                     end else begin
                        key = MAKE_TO_KEY[b[6:0]];
                        down = ~b[7];
                     end
                  end
                  sc1kt_pkg::PH_EXT: begin
                     seq_phase = sc1kt_pkg::PH_IDLE;
                     if (b == sc1kt_pkg::SC_FAKE_MAKE) begin
                        seq_phase = sc1kt_pkg::PH_FAKE_MAKE_SKIP;
                     end else if (b == sc1kt_pkg::SC_FAKE_BRK) begin
                        seq_phase = sc1kt_pkg::PH_FAKE_BRK_SKIP;
                     end else if (b != sc1kt_pkg::SC_EXT && b != sc1kt_pkg::SC_PAUSE) begin
                        key = extended_key(b[6:0]);
                        down = ~b[7];
                     end
                  end
                  sc1kt_pkg::PH_FAKE_MAKE_SKIP: seq_phase = sc1kt_pkg::PH_FAKE_MAKE_LAST;
                  sc1kt_pkg::PH_FAKE_BRK_SKIP:  seq_phase = sc1kt_pkg::PH_FAKE_BRK_LAST;
                  sc1kt_pkg::PH_FAKE_MAKE_LAST: begin
                     seq_phase = sc1kt_pkg::PH_IDLE;
                     key = fake_shift_key(1'b0, b);
                     down = 1'b1;
                  end
                  sc1kt_pkg::PH_FAKE_BRK_LAST: begin
                     seq_phase = sc1kt_pkg::PH_IDLE;
                     key = fake_shift_key(1'b1, b);
                     down = 1'b0;
                  end
                  default: seq_phase = sc1kt_pkg::PH_IDLE;
               endcase
               if (key != NO_KEY && key < KEY_SLOTS) begin
                  keys_down[key] = down;
                  r.event_valid = 1'b1;
                  r.event_key = key[6:0];
                  r.event_down = down;
               end
            end
         end
         default: begin
            // unused kind leaves everything alone
         end
      endcase
      return r;
   endfunction

   function automatic void queue_item(input logic [1:0] action, input logic [7:0] code,
                                      input logic [6:0] idx);
      stimulus.push_back('{action, code, idx, 1'b0, 16'h0000});
   endfunction

   // key_index is a don't-care on scan bytes, so it gets noise
   function automatic void queue_scan_byte(input logic [7:0] code);
      queue_item(sc1kt_pkg::ACT_SCAN, code, 7'($urandom));
   endfunction

   function automatic logic [7:0] random_plain_code();
      logic [7:0] code;
      do begin
         code = {1'($urandom_range(0, 1)), 7'($urandom_range(1, 8'h58))};
      end while (MAKE_TO_KEY[code[6:0]] == NO_KEY);
      return code;
   endfunction

   function automatic int field_miss(input string name, input int want, input int got);
      if (want != got) begin
         $display("t=%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // result side: random stall bursts, always ready near the end
   always @(posedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // every result item is matched against the oldest prediction
   always @(posedge clock) begin : rsp_check
      key_report_type want;
      key_report_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_reports.size() == 0) begin
            $display("t=%0t result item with nothing pending: expected none, actual %h",
                     $time, rsp_tdata);
            mismatches = mismatches + 1;
         end else begin
            want = expected_reports.pop_front();
            mismatches = mismatches
               + field_miss("key_held", want.key_held, got.key_held)
               + field_miss("key_went_down", want.key_went_down, got.key_went_down)
               + field_miss("key_went_up", want.key_went_up, got.key_went_up)
               + field_miss("event_valid", want.event_valid, got.event_valid)
               + field_miss("event_key", want.event_key, got.event_key)
               + field_miss("event_down", want.event_down, got.event_down)
               + field_miss("padding", want.zero, got.zero);
         end
      end
   end

   // watchdog: counts cycles in which no item moves on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus_run
      int             counted;
      int             pick;
      logic           releasing;
      logic [7:0]     tail_byte;
      key_report_type report;

      // predictor starts from the reset state
      keys_down = '0;
      keys_at_refresh = '0;
      seq_phase = sc1kt_pkg::PH_IDLE;
      pause_left = 3'd0;

      for (int i = 0; i < DIRECTED_ROWS; i++) stimulus.push_back(DIRECTED[i]);

      // random part: mostly well-formed sequences with random content
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            queue_scan_byte(random_plain_code());
            counted = counted + 1;
         end else if (pick < 45) begin
            queue_scan_byte(sc1kt_pkg::SC_EXT);
            if ($urandom_range(0, 5) == 0) begin
               queue_scan_byte(8'($urandom_range(1, 255)));  // broken extended pair
            end else begin
               queue_scan_byte({1'($urandom_range(0, 1)), EXT_CODES[$urandom_range(0, 16)]});
            end
            counted = counted + 2;
         end else if (pick < 61) begin
            releasing = (pick >= 53);
            queue_scan_byte(sc1kt_pkg::SC_EXT);
            queue_scan_byte(releasing ? sc1kt_pkg::SC_FAKE_BRK : sc1kt_pkg::SC_FAKE_MAKE);
            // the inner byte is skipped whatever it is
            if ($urandom_range(0, 3) != 0) queue_scan_byte(sc1kt_pkg::SC_EXT);
            else queue_scan_byte(8'($urandom_range(1, 255)));
            if ($urandom_range(0, 5) == 0) tail_byte = 8'($urandom_range(1, 255));
            else if (releasing) tail_byte = FAKE_RELEASE_CODES[$urandom_range(0, 4)];
            else tail_byte = FAKE_PRESS_CODES[$urandom_range(0, 4)];
            queue_scan_byte(tail_byte);
            counted = counted + 4;
         end else if (pick < 65) begin
            queue_scan_byte(sc1kt_pkg::SC_PAUSE);
            repeat (5) queue_scan_byte(8'($urandom_range(1, 255)));
            counted = counted + 6;
         end else if (pick < 75) begin
            queue_item(sc1kt_pkg::ACT_REFRESH, 8'($urandom), 7'($urandom));
            counted = counted + 1;
         end else if (pick < 90) begin
            // at least half of the queries land on key numbers that can be written
            queue_item(sc1kt_pkg::ACT_QUERY, 8'($urandom),
                       7'($urandom_range(0, 1) ? $urandom_range(0, 102) : $urandom_range(0, 127)));
            counted = counted + 1;
         end else begin
            // noise: any kind, any byte, nulls now and then
            queue_item(2'($urandom), ($urandom_range(0, 7) == 0) ? sc1kt_pkg::SC_NULL : 8'($urandom),
                       7'($urandom));
            counted = counted + 1;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < stimulus.size(); n++) begin
         calm = (n >= stimulus.size() - CALM_TAIL);
         if (n == DIRECTED_ROWS) begin
            // hold off until the directed part has fully drained
            req_tvalid <= 1'b0;
            do @(posedge clock); while (expected_reports.size() != 0);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tuser <= stimulus[n].action;
         req_tdata <= {1'b0, stimulus[n].key_index, stimulus[n].scan_byte};
         do @(posedge clock); while (!req_tready);
         // accepted at this edge: predict in acceptance order
         report = predict_key_report(stimulus[n]);
         if (stimulus[n].fixed_report) expected_reports.push_back(stimulus[n].report_bits);
         else expected_reports.push_back(report);
      end
      req_tvalid <= 1'b0;

      while (expected_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);  // catch any stray result item
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/sc1kt_pkg.sv
hw/rtl/scancode_set1_key_tracker.sv
tb/scancode_set1_key_tracker_tb.sv
